// ===== rtl/png_chunk_framer_crc32_assert.svh =====
// ---------------------------------------------------------------------------
// PNG chunk framer assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PNG_CHUNK_FRAMER_CRC32_ASSERT_SVH
`define PNG_CHUNK_FRAMER_CRC32_ASSERT_SVH

`ifndef SYNTH
// check on every clock edge outside reset
`define PCF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define PCF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCF_ASSERT(label, clk, rst_n, prop, msg)
`define PCF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/pcf_pkg.sv =====
// ---------------------------------------------------------------------------
// PNG chunk framer package
// Byte positions of the PNG frame, register indexes and the CRC-32 step.
// ---------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    typedef logic [5:0] t_pos;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // byte positions within one image frame
    localparam t_pos POS_SIG       = 6'd0;   // signature, 8 bytes
    localparam t_pos POS_IHDR_LEN  = 6'd8;
    localparam t_pos POS_IHDR_TYPE = 6'd12;  // first byte covered by IHDR CRC
    localparam t_pos POS_IHDR_BODY = 6'd16;
    localparam t_pos POS_IHDR_CRC  = 6'd29;
    localparam t_pos POS_IDAT_LEN  = 6'd33;
    localparam t_pos POS_IDAT_TYPE = 6'd37;  // first byte covered by IDAT CRC
    localparam t_pos POS_DATA      = 6'd41;
    localparam t_pos POS_IDAT_CRC  = 6'd42;
    localparam t_pos POS_IEND_LEN  = 6'd46;
    localparam t_pos POS_IEND_TYPE = 6'd50;
    localparam t_pos POS_IEND_CRC  = 6'd54;
    localparam t_pos POS_EOF       = 6'd57;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
    // CRC-32 of the fixed IEND chunk type
    localparam logic [31:0] IEND_CRC     = 32'hAE426082;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [30:0] stream_length;
    } t_item;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcf_in_if.sv =====
// ---------------------------------------------------------------------------
// PNG chunk framer input channel
// Valid/ready channel carrying one compressed byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pcf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        is_last;
    logic [30:0] stream_length;

    modport source (output valid, output data_byte, output is_last, output stream_length,
                    input ready);
    modport sink   (input valid, input data_byte, input is_last, input stream_length,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pcf_out_if.sv =====
// ---------------------------------------------------------------------------
// PNG chunk framer output channel
// Valid/ready channel carrying one PNG file byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;

    modport source (output valid, output out_byte, output last_of_run, output end_of_file,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input end_of_file,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pcf_byte_mux.sv =====
// ---------------------------------------------------------------------------
// PNG chunk framer byte selector
// Picks the file byte for a frame position: constants, header fields, CRCs, data.
// ---------------------------------------------------------------------------
`default_nettype none

module pcf_byte_mux (
    input  wire pcf_pkg::t_pos  i_pos,
    input  wire logic [15:0]    i_width,
    input  wire logic [15:0]    i_height,
    input  wire pcf_pkg::t_item i_item,
    input  wire logic [31:0]    i_crc,
    output logic [7:0]          o_byte
);
    import pcf_pkg::*;

    logic [31:0] w_crc_out;
    logic [31:0] w_slen;

    assign w_crc_out = i_crc ^ CRC_ALL_ONES;
    assign w_slen    = {1'b0, i_item.stream_length};

    always_comb begin
        unique case (i_pos)
            POS_SIG + 6'd0:        o_byte = 8'h89;
            POS_SIG + 6'd1:        o_byte = 8'h50;
            POS_SIG + 6'd2:        o_byte = 8'h4E;
            POS_SIG + 6'd3:        o_byte = 8'h47;
            POS_SIG + 6'd4:        o_byte = 8'h0D;
            POS_SIG + 6'd5:        o_byte = 8'h0A;
            POS_SIG + 6'd6:        o_byte = 8'h1A;
            POS_SIG + 6'd7:        o_byte = 8'h0A;
            POS_IHDR_LEN + 6'd3:   o_byte = 8'd13;
            POS_IHDR_TYPE + 6'd0:  o_byte = 8'h49;
            POS_IHDR_TYPE + 6'd1:  o_byte = 8'h48;
            POS_IHDR_TYPE + 6'd2:  o_byte = 8'h44;
            POS_IHDR_TYPE + 6'd3:  o_byte = 8'h52;
            POS_IHDR_BODY + 6'd2:  o_byte = i_width[15:8];
            POS_IHDR_BODY + 6'd3:  o_byte = i_width[7:0];
            POS_IHDR_BODY + 6'd6:  o_byte = i_height[15:8];
            POS_IHDR_BODY + 6'd7:  o_byte = i_height[7:0];
            POS_IHDR_BODY + 6'd8:  o_byte = 8'd8;   // bit depth
            POS_IHDR_BODY + 6'd9:  o_byte = 8'd6;   // RGBA
            POS_IHDR_CRC + 6'd0,
            POS_IDAT_CRC + 6'd0:   o_byte = w_crc_out[31:24];
            POS_IHDR_CRC + 6'd1,
            POS_IDAT_CRC + 6'd1:   o_byte = w_crc_out[23:16];
            POS_IHDR_CRC + 6'd2,
            POS_IDAT_CRC + 6'd2:   o_byte = w_crc_out[15:8];
            POS_IHDR_CRC + 6'd3,
            POS_IDAT_CRC + 6'd3:   o_byte = w_crc_out[7:0];
            POS_IDAT_LEN + 6'd0:   o_byte = w_slen[31:24];
            POS_IDAT_LEN + 6'd1:   o_byte = w_slen[23:16];
            POS_IDAT_LEN + 6'd2:   o_byte = w_slen[15:8];
            POS_IDAT_LEN + 6'd3:   o_byte = w_slen[7:0];
            POS_IDAT_TYPE + 6'd0:  o_byte = 8'h49;
            POS_IDAT_TYPE + 6'd1:  o_byte = 8'h44;
            POS_IDAT_TYPE + 6'd2:  o_byte = 8'h41;
            POS_IDAT_TYPE + 6'd3:  o_byte = 8'h54;
            POS_DATA:              o_byte = i_item.data_byte;
            POS_IEND_TYPE + 6'd0:  o_byte = 8'h49;
            POS_IEND_TYPE + 6'd1:  o_byte = 8'h45;
            POS_IEND_TYPE + 6'd2:  o_byte = 8'h4E;
            POS_IEND_TYPE + 6'd3:  o_byte = 8'h44;
            POS_IEND_CRC + 6'd0:   o_byte = IEND_CRC[31:24];
            POS_IEND_CRC + 6'd1:   o_byte = IEND_CRC[23:16];
            POS_IEND_CRC + 6'd2:   o_byte = IEND_CRC[15:8];
            POS_IEND_CRC + 6'd3:   o_byte = IEND_CRC[7:0];
            // zero fields of the length words and IHDR body
            default:               o_byte = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/png_chunk_framer_crc32.sv =====
// ---------------------------------------------------------------------------
// PNG chunk framer with CRC-32
// Wraps a compressed zlib byte stream into signature, IHDR, IDAT and IEND.
// ---------------------------------------------------------------------------
// The block emits one file byte per cycle from an output register while the
// receiver is ready, and takes a new middle data byte every cycle then. The
// first byte of an image goes out after 41 header bytes; the last is followed
// by the IDAT CRC and IEND. The input stalls meanwhile. The output register
// has a single byte lane. The CRC register folds one byte per cycle as the
// covered bytes are sent out.
`default_nettype none

module png_chunk_framer_crc32 (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcf_in_if.sink     i_in,
    pcf_out_if.source  o_out,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import pcf_pkg::*;

    logic [15:0] r_width;
    logic [15:0] r_height;
    logic        r_in_image;
    logic        r_busy;
    t_pos        r_pos;
    t_pos        r_end;
    t_item       r_item;
    logic [31:0] r_crc;
    logic        r_ov;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_eof;

    logic        w_accept;
    logic        w_fire;
    logic        w_final;
    logic [7:0]  w_byte;
    logic [31:0] w_crc_base;
    logic        w_crc_fold;

    assign w_fire   = r_busy && (!r_ov || o_out.ready);
    assign w_final  = r_pos == r_end;
    assign i_in.ready = !r_busy || (w_fire && w_final);
    assign w_accept = i_in.valid && i_in.ready;

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;
    assign o_out.end_of_file = r_out_eof;

    pcf_byte_mux u_byte_mux (
        .i_pos    (r_pos),
        .i_width  (r_width),
        .i_height (r_height),
        .i_item   (r_item),
        .i_crc    (r_crc),
        .o_byte   (w_byte)
    );

    // restart the CRC at the first covered byte of the IHDR and IDAT chunks
    assign w_crc_base = (r_pos == POS_IHDR_TYPE || r_pos == POS_IDAT_TYPE) ? CRC_ALL_ONES
                                                                           : r_crc;
    assign w_crc_fold = (r_pos >= POS_IHDR_TYPE && r_pos < POS_IHDR_CRC)
                     || (r_pos >= POS_IDAT_TYPE && r_pos <= POS_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 16'd1;
            r_height   <= 16'd1;
            r_in_image <= 1'b0;
            r_busy     <= 1'b0;
            r_pos      <= POS_SIG;
            r_end      <= POS_DATA;
            r_crc      <= CRC_ALL_ONES;
            r_ov       <= 1'b0;
            r_out_last <= 1'b0;
            r_out_eof  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (w_fire) begin
                r_ov       <= 1'b1;
                r_out_byte <= w_byte;
                r_out_last <= w_final;
                r_out_eof  <= r_pos == POS_EOF;
                if (w_crc_fold) begin
                    r_crc <= crc32_byte(w_crc_base, w_byte);
                end
                if (w_final) begin
                    // stay busy when the next beat is taken at this edge
                    if (!w_accept) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_pos <= r_pos + 6'd1;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            // take the next beat; a first byte never closes the image
            if (w_accept) begin
                r_busy               <= 1'b1;
                r_item.data_byte     <= i_in.data_byte;
                r_item.stream_length <= i_in.stream_length;
                r_pos                <= r_in_image ? POS_DATA : POS_SIG;
                r_end                <= (r_in_image && i_in.is_last) ? POS_EOF : POS_DATA;
                r_in_image           <= !(r_in_image && i_in.is_last);
            end
        end
    end

`include "png_chunk_framer_crc32_assert.svh"

    `PCF_ASSERT(a_pos_bound, i_clk, i_rst_n, r_busy |-> (r_pos <= r_end), "position past end")
    `PCF_ASSERT(a_eof_last, i_clk, i_rst_n, (o_out.valid && o_out.end_of_file) |-> o_out.last_of_run, "eof without last")
    `PCF_ASSERT(a_accept_slot, i_clk, i_rst_n, (w_accept && r_busy) |-> (w_fire && w_final), "beat taken mid burst")
    `PCF_ASSERT(a_first_start, i_clk, i_rst_n, (w_accept && !r_in_image) |=> (r_pos == POS_SIG && r_end == POS_DATA), "first beat misframed")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// PNG chunk framer testbench
// Streams compressed bytes into the framer and checks every PNG file byte it
// emits against an in-bench frame predictor. A directed table covers reset
// values, size extremes, a first byte flagged last and zero lengths. Random
// images with random stalls on both channels follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import pcf_pkg::*;

    localparam int          NUM_BEATS   = 270;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          DRAIN_TAIL  = 16;
    localparam int          MAX_REPORTS = 10;
    localparam int          NO_CHECK    = -1;
    localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT  = 32'hFFFFFFFF;
    localparam int          NUM_ROWS    = 20;

    typedef enum logic { ROW_BEAT, ROW_CFG } stim_kind_e;

    typedef struct {
        stim_kind_e  kind;
        logic [7:0]  data_byte;
        logic        is_last;
        logic [30:0] stream_length;
        logic        cfg_index;
        logic [15:0] cfg_value;
        int          chk_off;    // byte offset of a typed-in word, or NO_CHECK
        logic [31:0] chk_word;
    } stim_row_t;

    typedef struct {
        int          off;
        logic [31:0] word;
    } typed_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_file;
    } png_byte_t;

    logic i_clk;
    logic i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    pcf_in_if  in_ch ();
    pcf_out_if out_ch ();

    png_chunk_framer_crc32 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // frame predictor state
    logic        pred_in_image;
    logic [31:0] pred_idat_crc;
    logic [15:0] pred_width;
    logic [15:0] pred_height;
    logic [7:0]  run_buf [0:63];
    int          run_len;

    png_byte_t   png_bytes_q [$];
    typed_word_t typed_q [$];

    int          err_count;
    int          beats_sent;
    int          rx_beats;
    int          tx_gap_max;
    int          rx_stall_max;
    int          idle_cycles;
    stim_row_t   directed_rows [0:NUM_ROWS-1];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) c = c ^ CRC32_POLY;
        end
        return c;
    endfunction

    task automatic append_byte(input logic [7:0] b);
        run_buf[run_len] = b;
        run_len++;
    endtask

    task automatic append_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) append_byte(w[8*k +: 8]);
    endtask

    // Build the file bytes one accepted beat causes and queue them.
    task automatic frame_png_run(input logic [7:0] d, input logic l, input logic [30:0] s,
                                 input typed_word_t tw);
        logic [31:0] crc;
        logic        closing;
        png_byte_t   pb;
        closing = l;
        run_len = 0;
        if (!pred_in_image) begin
            append_word(32'h89504E47);
            append_word(32'h0D0A1A0A);
            append_word(32'd13);
            append_word("IHDR");
            append_word({16'd0, pred_width});
            append_word({16'd0, pred_height});
            append_byte(8'd8);
            append_byte(8'd6);
            append_byte(8'd0);
            append_byte(8'd0);
            append_byte(8'd0);
            crc = CRC32_INIT;
            for (int i = 12; i < 29; i++) crc = crc32_fold(crc, run_buf[i]);
            append_word(~crc);
            append_word({1'b0, s});
            append_word("IDAT");
            pred_idat_crc = CRC32_INIT;
            for (int i = 37; i < 41; i++) pred_idat_crc = crc32_fold(pred_idat_crc, run_buf[i]);
            pred_in_image = 1'b1;
            // a first byte never closes the image
            closing = 1'b0;
        end
        append_byte(d);
        pred_idat_crc = crc32_fold(pred_idat_crc, d);
        if (closing) begin
            append_word(~pred_idat_crc);
            append_word(32'd0);
            append_word("IEND");
            crc = CRC32_INIT;
            for (int i = run_len - 4; i < run_len; i++) crc = crc32_fold(crc, run_buf[i]);
            append_word(~crc);
            pred_in_image = 1'b0;
            pred_idat_crc = CRC32_INIT;
        end
        if (tw.off != NO_CHECK) begin
            for (int k = 0; k < 4; k++) run_buf[tw.off + k] = tw.word[31 - 8*k -: 8];
        end
        for (int i = 0; i < run_len; i++) begin
            pb.out_byte    = run_buf[i];
            pb.last_of_run = (i == run_len - 1);
            pb.end_of_file = closing && (i == run_len - 1);
            png_bytes_q.push_back(pb);
        end
    endtask

    // Input and output monitors share one block: accept first, then check.
    always @(posedge i_clk) begin
        typed_word_t tw;
        png_byte_t   exp_b;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tw.off  = NO_CHECK;
                tw.word = 32'd0;
                if (typed_q.size() != 0) tw = typed_q.pop_front();
                frame_png_run(in_ch.data_byte, in_ch.is_last, in_ch.stream_length, tw);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (png_bytes_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected beat: byte %02h last %0b eof %0b",
                                 out_ch.out_byte, out_ch.last_of_run, out_ch.end_of_file);
                end else begin
                    exp_b = png_bytes_q.pop_front();
                    if (out_ch.out_byte !== exp_b.out_byte ||
                        out_ch.last_of_run !== exp_b.last_of_run ||
                        out_ch.end_of_file !== exp_b.end_of_file) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("mismatch: expected byte %02h last %0b eof %0b, got byte %02h last %0b eof %0b",
                                     exp_b.out_byte, exp_b.last_of_run, exp_b.end_of_file,
                                     out_ch.out_byte, out_ch.last_of_run, out_ch.end_of_file);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall before each beat, with stall-free stretches.
    initial begin
        int stall;
        rx_beats = 0;
        rx_stall_max = 5;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_beats % 50 == 0) rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
            rx_beats++;
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic l, input logic [30:0] s,
                             input int off, input logic [31:0] w);
        int          gap;
        typed_word_t tw;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tw.off  = off;
        tw.word = w;
        typed_q.push_back(tw);
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= d;
        in_ch.is_last       <= l;
        in_ch.stream_length <= s;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
        beats_sent++;
    endtask

    // Hold the input until every queued file byte has come out.
    task automatic settle_frame();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (png_bytes_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        settle_frame();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_WIDTH) pred_width = val;
        else                  pred_height = val;
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          img_len;
        int          img_no;
        logic [30:0] slen;
        logic        lst;
        err_count     = 0;
        beats_sent    = 0;
        idle_cycles   = 0;
        tx_gap_max    = 5;
        pred_in_image = 1'b0;
        pred_idat_crc = CRC32_INIT;
        pred_width    = 16'd1;
        pred_height   = 16'd1;

        directed_rows = '{
            // reset sizes: 1x1 RGBA header
            '{ROW_BEAT, 8'h00, 1'b0, 31'd3,          CFG_WIDTH, 16'd0, 29, 32'h1F15C489},
            '{ROW_BEAT, 8'hFF, 1'b0, 31'h2AAAAAAA,   CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'hA5, 1'b1, 31'h55555555,   CFG_WIDTH, 16'd0, 13, 32'hAE426082},
            // first byte flagged last is not an end; longest stream length
            '{ROW_BEAT, 8'h80, 1'b1, 31'h7FFFFFFF,   CFG_WIDTH, 16'd0, 33, 32'h7FFFFFFF},
            '{ROW_BEAT, 8'h01, 1'b0, 31'd0,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'h7F, 1'b1, 31'd0,          CFG_WIDTH, 16'd0, 13, 32'hAE426082},
            '{ROW_CFG,  8'h00, 1'b0, 31'd0,          CFG_WIDTH, 16'hFFFF, NO_CHECK, 32'd0},
            '{ROW_CFG,  8'h00, 1'b0, 31'd0,          CFG_HEIGHT, 16'hFFFF, NO_CHECK, 32'd0},
            // zero stream length goes out as given
            '{ROW_BEAT, 8'h55, 1'b1, 31'd0,          CFG_WIDTH, 16'd0, 33, 32'd0},
            '{ROW_BEAT, 8'hAA, 1'b1, 31'd0,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_CFG,  8'h00, 1'b0, 31'd0,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_CFG,  8'h00, 1'b0, 31'd0,          CFG_HEIGHT, 16'd0, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'h33, 1'b0, 31'd12345,      CFG_WIDTH, 16'd0, 0, 32'h89504E47},
            '{ROW_BEAT, 8'hC3, 1'b0, 31'd1,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'h3C, 1'b1, 31'd2,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_CFG,  8'h00, 1'b0, 31'd0,          CFG_WIDTH, 16'd640, NO_CHECK, 32'd0},
            '{ROW_CFG,  8'h00, 1'b0, 31'd0,          CFG_HEIGHT, 16'd480, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'h0F, 1'b0, 31'd3,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'hF0, 1'b0, 31'd0,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0},
            '{ROW_BEAT, 8'h96, 1'b1, 31'd0,          CFG_WIDTH, 16'd0, NO_CHECK, 32'd0}
        };

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_WIDTH;
        i_cfg_data          <= 16'd0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= 8'd0;
        in_ch.is_last       <= 1'b0;
        in_ch.stream_length <= 31'd0;
        out_ch.ready        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].cfg_index, directed_rows[r].cfg_value);
            else
                send_beat(directed_rows[r].data_byte, directed_rows[r].is_last,
                          directed_rows[r].stream_length, directed_rows[r].chk_off,
                          directed_rows[r].chk_word);
        end

        img_no = 0;
        while (beats_sent < NUM_BEATS) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1)) write_reg(CFG_WIDTH, pick_size());
                if ($urandom_range(0, 1)) write_reg(CFG_HEIGHT, pick_size());
            end
            // drain fully once before a new image
            if (img_no == 4) settle_frame();
            img_len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(2, 12);
            slen       = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'(img_len);
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            for (int k = 0; k < img_len; k++) begin
                // is_last on the first byte is noise; later ones end on the final byte
                lst = (k == 0) ? 1'($urandom_range(0, 1)) : (k == img_len - 1);
                send_beat(8'($urandom), lst, (k == 0) ? slen : 31'($urandom),
                          NO_CHECK, 32'd0);
            end
            img_no++;
        end

        settle_frame();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (err_count == 0 && png_bytes_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
